[design/idu_pkg.sv]
// Shared types and constants for the integer divide unit.
// No dependencies; used by idu_div_stage and int_divide_unit_signed_unsigned.
package idu_pkg;

	localparam int DATA_W     = 32;
	localparam int STEP_BITS  = 4;
	localparam int DIV_STAGES = DATA_W / STEP_BITS;

	typedef enum logic {
		OP_DIV  = 1'b0,
		OP_DIVU = 1'b1
	} idu_op_t;

	// Payload carried down the divide pipeline
	typedef struct packed {
		logic              lane;
		logic              neg_q;
		logic              neg_r;
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] acc;
		logic [DATA_W-1:0] dvsr;
	} idu_stage_t;

endpackage

[design/idu_div_stage.sv]
// One register stage of the restoring divider: STEP_BITS quotient bits per stage.
// Depends on idu_pkg.
module idu_div_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                vld_in,
	input  idu_pkg::idu_stage_t d_in,
	output logic                vld_sn,
	output idu_pkg::idu_stage_t data_sn
);

	logic [idu_pkg::DATA_W:0] part;
	logic [idu_pkg::DATA_W:0] diff;
	idu_pkg::idu_stage_t      nxt;

	// For each of STEP_BITS steps: shift in one dividend bit, trial subtract, keep difference when no borrow
	always_comb begin
		nxt  = d_in;
		part = '0;
		diff = '0;
		for (int i = 0; i < idu_pkg::STEP_BITS; i++) begin
			part = {nxt.rem, nxt.acc[idu_pkg::DATA_W-1]};
			diff = part - {1'b0, nxt.dvsr};
			if (!diff[idu_pkg::DATA_W]) begin
				nxt.rem = diff[idu_pkg::DATA_W-1:0];
				nxt.acc = {nxt.acc[idu_pkg::DATA_W-2:0], 1'b1};
			end else begin
				nxt.rem = part[idu_pkg::DATA_W-1:0];
				nxt.acc = {nxt.acc[idu_pkg::DATA_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= 1'b0;
		end else if (adv) begin
			vld_sn <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_sn <= nxt;
		end
	end

endmodule

[design/int_divide_unit_signed_unsigned.sv]
// Pipelined 32-bit integer divider for signed (DIV) and unsigned (DIVU) opcodes.
// Depends on idu_pkg and idu_div_stage.
//
// Usage: present op, pipe, dividend and divisor with req_valid; the transaction
// is taken at a clock edge where req_valid is high and req_stall is low. Each
// transaction yields exactly one result transaction (lane, quotient for LO,
// remainder for HI) in issue order, on rsp_valid / rsp_stall. The block takes
// one transaction per cycle while req_stall is low, and every transaction
// passes through DIV_STAGES + 2 = 10 register stages: one input stage that
// takes magnitudes, eight restoring-divide stages that each resolve four
// quotient bits (the four chained 33-bit trial subtractions set the stage
// depth), and one output stage that restores signs. The whole pipeline
// advances together;
// it holds only while a result sits in the output register and rsp_stall is
// high, and then req_stall is raised. Quotients truncate toward zero and the
// remainder takes the sign of the dividend. A zero divisor gives an all-ones
// quotient in unsigned mode, and in signed mode 1 for a negative dividend and
// -1 otherwise, with the dividend as remainder; the most negative dividend over
// -1 gives the most negative quotient and remainder zero. All of these fall out
// of the magnitude datapath without special-case logic.
module int_divide_unit_signed_unsigned (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               op,
	input  logic               pipe,
	input  logic        [31:0] dividend,
	input  logic        [31:0] divisor,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic               lane,
	output logic signed [31:0] quotient,
	output logic signed [31:0] remainder
);

	localparam int DW = idu_pkg::DATA_W;

	logic                adv;
	logic                neg_a;
	logic                neg_b;
	logic                vld_s1;
	idu_pkg::idu_stage_t data_s1;
	logic                div_vld  [idu_pkg::DIV_STAGES+1];
	idu_pkg::idu_stage_t div_data [idu_pkg::DIV_STAGES+1];
	logic                vld_s10;
	logic                lane_s10;
	logic [DW-1:0]       quo_s10;
	logic [DW-1:0]       rem_s10;

	// Advance everything unless the output register is full and held
	assign adv       = !(vld_s10 && rsp_stall);
	assign req_stall = !adv;

	// Input stage: take magnitudes and record result signs
	assign neg_a = (op == idu_pkg::OP_DIV) && dividend[DW-1];
	assign neg_b = (op == idu_pkg::OP_DIV) && divisor[DW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1.lane  <= pipe;
			data_s1.neg_q <= neg_a ^ neg_b;
			data_s1.neg_r <= neg_a;
			data_s1.rem   <= '0;
			data_s1.acc   <= neg_a ? (DW'(0) - dividend) : dividend;
			data_s1.dvsr  <= neg_b ? (DW'(0) - divisor) : divisor;
		end
	end

	assign div_vld[0]  = vld_s1;
	assign div_data[0] = data_s1;

	// Divide stages: four quotient bits each
	for (genvar g = 0; g < idu_pkg::DIV_STAGES; g++) begin : g_div
		idu_div_stage u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.vld_in  (div_vld[g]),
			.d_in    (div_data[g]),
			.vld_sn  (div_vld[g+1]),
			.data_sn (div_data[g+1])
		);
	end

	// Output stage: apply signs, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (adv) begin
			vld_s10 <= div_vld[idu_pkg::DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lane_s10 <= div_data[idu_pkg::DIV_STAGES].lane;
			quo_s10  <= div_data[idu_pkg::DIV_STAGES].neg_q
				? (DW'(0) - div_data[idu_pkg::DIV_STAGES].acc)
				: div_data[idu_pkg::DIV_STAGES].acc;
			rem_s10  <= div_data[idu_pkg::DIV_STAGES].neg_r
				? (DW'(0) - div_data[idu_pkg::DIV_STAGES].rem)
				: div_data[idu_pkg::DIV_STAGES].rem;
		end
	end

	assign rsp_valid = vld_s10;
	assign lane      = lane_s10;
	assign quotient  = $signed(quo_s10);
	assign remainder = $signed(rem_s10);

`ifndef SYNTH
	// Finished partial remainder is always below a nonzero divisor
	a_rem_below_dvsr: assert property (@(posedge clk) disable iff (!arst_n)
		(div_vld[idu_pkg::DIV_STAGES] && (div_data[idu_pkg::DIV_STAGES].dvsr != '0))
		|-> (div_data[idu_pkg::DIV_STAGES].rem < div_data[idu_pkg::DIV_STAGES].dvsr))
		else $error("divider remainder not below divisor");

	// The valid bit moves from the last divide stage into the output register on each advance
	a_vld_moves: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (vld_s10 == $past(div_vld[idu_pkg::DIV_STAGES])))
		else $error("valid bit lost between last divide stage and output");

	// A stalled result stays put until it is taken
	a_stalled_rsp_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(lane)
			&& $stable(quotient) && $stable(remainder)))
		else $error("stalled result changed before it was taken");
`endif

endmodule
